### rtl/euler_xyz_to_rigid_transform_macros.svh
// Assertion helpers used by the queue of the pose transform.
`ifndef EULER_XYZ_TO_RIGID_TRANSFORM_MACROS_SVH
`define EULER_XYZ_TO_RIGID_TRANSFORM_MACROS_SVH

// A condition that must never hold while out of reset.
`define ETRT_ASSERT_NEVER(lbl, clk_, rst_n_, cond, msg) \
	lbl: assert property (@(posedge clk_) disable iff (!(rst_n_)) !(cond)) \
		else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ETRT_ASSERT_NEXT(lbl, clk_, rst_n_, ante, cons, msg) \
	lbl: assert property (@(posedge clk_) disable iff (!(rst_n_)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/etrt_pkg.sv
// ----------------------------------------------------------------------------
// etrt_pkg
// Types and constants for the Euler pose to rigid transform block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package etrt_pkg;

	localparam int ATAN_LEN = 24;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	localparam logic signed [35:0] Q30_GAIN    = 36'sd652032874;
	localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;

	typedef struct packed {
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [31:0] shift_z;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
		logic signed [31:0] out_shift_x;
		logic signed [31:0] out_shift_y;
		logic signed [31:0] out_shift_z;
	} xform_t;

	// Sines and cosines in Q.30 plus the translations, one queue entry.
	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] cx;
		logic signed [31:0] sy;
		logic signed [31:0] cy;
		logic signed [31:0] sz;
		logic signed [31:0] cz;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [31:0] shift_z;
	} trig_t;

	// Handshake between two parts of the block.
	typedef struct packed {
		logic valid;
		logic stall;
	} hs_t;

	function automatic logic signed [35:0] atan_q30(input int idx);
		logic signed [35:0] r;
		case (idx)
			0:       r = 36'sd843314856;
			1:       r = 36'sd497837829;
			2:       r = 36'sd263043836;
			3:       r = 36'sd133525158;
			4:       r = 36'sd67021686;
			5:       r = 36'sd33543515;
			6:       r = 36'sd16775850;
			7:       r = 36'sd8388437;
			8:       r = 36'sd4194282;
			9:       r = 36'sd2097149;
			10:      r = 36'sd1048575;
			11:      r = 36'sd524287;
			12:      r = 36'sd262143;
			13:      r = 36'sd131071;
			14:      r = 36'sd65535;
			15:      r = 36'sd32767;
			16:      r = 36'sd16383;
			17:      r = 36'sd8191;
			18:      r = 36'sd4095;
			19:      r = 36'sd2047;
			20:      r = 36'sd1023;
			21:      r = 36'sd511;
			22:      r = 36'sd255;
			23:      r = 36'sd127;
			default: r = 36'sd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/etrt_front.sv
// ----------------------------------------------------------------------------
// etrt_front
// Pipelined quadrant fold and CORDIC for the three angles, one stage a step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module etrt_front import etrt_pkg::*; #(
	parameter int NSTEPS = 14
) (
	input  logic  clk,
	input  logic  arst_n,
	input  hs_t   in_hs_i,
	input  pose_t pose_i,
	input  logic  en,
	output logic  push,
	output trig_t trig
);

	typedef struct packed {
		logic signed [35:0] x;
		logic signed [35:0] y;
		logic signed [35:0] z;
		logic               neg;
	} lane_t;

	lane_t lane_s [0:NSTEPS][3];
	pose_t pose_s [0:NSTEPS];
	logic  vld_s  [0:NSTEPS];

	function automatic lane_t fold(input logic signed [15:0] a);
		lane_t l;
		logic signed [35:0] z;
		z = {{3{a[15]}}, a, 17'b0};
		l.x = Q30_GAIN;
		l.y = '0;
		l.neg = 1'b0;
		if (z > Q30_HALF_PI) begin
			z = z - Q30_PI;
			l.neg = 1'b1;
		end else if (z < -Q30_HALF_PI) begin
			z = z + Q30_PI;
			l.neg = 1'b1;
		end
		l.z = z;
		return l;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_hs_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pose_s[0]    <= pose_i;
			lane_s[0][0] <= fold(pose_i.angle_x);
			lane_s[0][1] <= fold(pose_i.angle_y);
			lane_s[0][2] <= fold(pose_i.angle_z);
		end
	end

	for (genvar i = 0; i < NSTEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		for (genvar k = 0; k < 3; k++) begin : g_lane
			always_ff @(posedge clk) begin
				if (en) begin
					lane_s[i+1][k].neg <= lane_s[i][k].neg;
					if (!lane_s[i][k].z[35]) begin
						lane_s[i+1][k].x <= lane_s[i][k].x - (lane_s[i][k].y >>> i);
						lane_s[i+1][k].y <= lane_s[i][k].y + (lane_s[i][k].x >>> i);
						lane_s[i+1][k].z <= lane_s[i][k].z - atan_q30(i);
					end else begin
						lane_s[i+1][k].x <= lane_s[i][k].x + (lane_s[i][k].y >>> i);
						lane_s[i+1][k].y <= lane_s[i][k].y - (lane_s[i][k].x >>> i);
						lane_s[i+1][k].z <= lane_s[i][k].z + atan_q30(i);
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pose_s[i+1] <= pose_s[i];
			end
		end
	end

	function automatic logic signed [31:0] sgn(input lane_t l, input logic take_y);
		logic signed [35:0] v;
		v = take_y ? l.y : l.x;
		if (l.neg) begin
			v = -v;
		end
		return v[31:0];
	endfunction

	assign push = en && vld_s[NSTEPS];
	always_comb begin
		trig.sx      = sgn(lane_s[NSTEPS][0], 1'b1);
		trig.cx      = sgn(lane_s[NSTEPS][0], 1'b0);
		trig.sy      = sgn(lane_s[NSTEPS][1], 1'b1);
		trig.cy      = sgn(lane_s[NSTEPS][1], 1'b0);
		trig.sz      = sgn(lane_s[NSTEPS][2], 1'b1);
		trig.cz      = sgn(lane_s[NSTEPS][2], 1'b0);
		trig.shift_x = pose_s[NSTEPS].shift_x;
		trig.shift_y = pose_s[NSTEPS].shift_y;
		trig.shift_z = pose_s[NSTEPS].shift_z;
	end

endmodule

### rtl/etrt_queue.sv
// ----------------------------------------------------------------------------
// etrt_queue
// Short queue of sine and cosine sets between the CORDIC and the matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_xyz_to_rigid_transform_macros.svh"
module etrt_queue import etrt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  trig_t wdata,
	input  logic  pop,
	output logic  full,
	output logic  nonempty,
	output trig_t rdata
);

	trig_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wp_q;
	logic [QAW-1:0]   rp_q;
	logic [QAW:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	assign full     = (cnt_q == (QAW+1)'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rp_q];

	`ETRT_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "push into full queue")
	`ETRT_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && !nonempty, "pop from empty queue")
	`ETRT_ASSERT_NEXT(a_fill_tracks, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "count lost a push")

endmodule

### rtl/etrt_back.sv
// ----------------------------------------------------------------------------
// etrt_back
// Product pipeline forming the nine rotation entries, with output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module etrt_back import etrt_pkg::*; #(
	parameter int FRAC = 14
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_nonempty,
	input  trig_t  trig,
	output logic   pop,
	output hs_t    out_hs,
	input  logic   out_stall,
	output xform_t xform
);

	localparam int SH = 30 - FRAC;
	localparam logic signed [35:0] RND = (SH == 0) ? 36'sd0 : (36'sd1 <<< (SH - 1));
	localparam logic signed [35:0] LIM = 36'sd1 <<< FRAC;

	function automatic logic signed [32:0] mul30(input logic signed [32:0] a,
		input logic signed [32:0] b);
		logic signed [65:0] p;
		p = a * b;
		p = (p + 66'sd536870912) >>> 30;
		return p[32:0];
	endfunction

	function automatic logic [15:0] to_out(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = (v + RND) >>> SH;
		if (r > LIM) begin
			r = LIM;
		end
		if (r < -LIM) begin
			r = -LIM;
		end
		return r[15:0];
	endfunction

	logic en;
	logic v1_s, v2_s, vo_q;

	logic signed [32:0] sxsy_s1, cxsy_s1, cycz_s1, cysz_s1, sxcy_s1, cxcy_s1;
	logic signed [32:0] cxsz_s1, cxcz_s1, sxsz_s1, sxcz_s1, sy_s1, cz_s1, sz_s1;
	logic signed [31:0] tx_s1, ty_s1, tz_s1;

	logic signed [32:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [32:0] cycz_s2, cysz_s2, sxcy_s2, cxcy_s2;
	logic signed [32:0] cxsz_s2, cxcz_s2, sxsz_s2, sxcz_s2, sy_s2;
	logic signed [31:0] tx_s2, ty_s2, tz_s2;

	xform_t xform_q;

	assign en  = !(vo_q && out_stall);
	assign pop = en && q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
			v2_s <= 1'b0;
			vo_q <= 1'b0;
		end else if (en) begin
			v1_s <= q_nonempty;
			v2_s <= v1_s;
			vo_q <= v2_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sxsy_s1 <= mul30(33'(trig.sx), 33'(trig.sy));
			cxsy_s1 <= mul30(33'(trig.cx), 33'(trig.sy));
			cycz_s1 <= mul30(33'(trig.cy), 33'(trig.cz));
			cysz_s1 <= mul30(33'(trig.cy), 33'(trig.sz));
			sxcy_s1 <= mul30(33'(trig.sx), 33'(trig.cy));
			cxcy_s1 <= mul30(33'(trig.cx), 33'(trig.cy));
			cxsz_s1 <= mul30(33'(trig.cx), 33'(trig.sz));
			cxcz_s1 <= mul30(33'(trig.cx), 33'(trig.cz));
			sxsz_s1 <= mul30(33'(trig.sx), 33'(trig.sz));
			sxcz_s1 <= mul30(33'(trig.sx), 33'(trig.cz));
			sy_s1   <= 33'(trig.sy);
			cz_s1   <= 33'(trig.cz);
			sz_s1   <= 33'(trig.sz);
			tx_s1   <= trig.shift_x;
			ty_s1   <= trig.shift_y;
			tz_s1   <= trig.shift_z;

			pa_s2   <= mul30(sxsy_s1, cz_s1);
			pb_s2   <= mul30(sxsy_s1, sz_s1);
			pc_s2   <= mul30(cxsy_s1, cz_s1);
			pd_s2   <= mul30(cxsy_s1, sz_s1);
			cycz_s2 <= cycz_s1;
			cysz_s2 <= cysz_s1;
			sxcy_s2 <= sxcy_s1;
			cxcy_s2 <= cxcy_s1;
			cxsz_s2 <= cxsz_s1;
			cxcz_s2 <= cxcz_s1;
			sxsz_s2 <= sxsz_s1;
			sxcz_s2 <= sxcz_s1;
			sy_s2   <= sy_s1;
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			tz_s2   <= tz_s1;

			xform_q.r00 <= to_out(36'(cycz_s2));
			xform_q.r01 <= to_out(-36'(cysz_s2));
			xform_q.r02 <= to_out(36'(sy_s2));
			xform_q.r10 <= to_out(36'(pa_s2) + 36'(cxsz_s2));
			xform_q.r11 <= to_out(36'(cxcz_s2) - 36'(pb_s2));
			xform_q.r12 <= to_out(-36'(sxcy_s2));
			xform_q.r20 <= to_out(36'(sxsz_s2) - 36'(pc_s2));
			xform_q.r21 <= to_out(36'(pd_s2) + 36'(sxcz_s2));
			xform_q.r22 <= to_out(36'(cxcy_s2));
			xform_q.out_shift_x <= tx_s2;
			xform_q.out_shift_y <= ty_s2;
			xform_q.out_shift_z <= tz_s2;
		end
	end

	assign out_hs.valid = vo_q;
	assign out_hs.stall = out_stall;
	assign xform        = xform_q;

endmodule

### rtl/euler_xyz_to_rigid_transform.sv
// A pose beat passes the fold register, the CORDIC step registers, a queue entry,
// two product stages and the output register before its transform beat is valid.
// Throughput: one beat per cycle when nothing stalls, set by the fully pipelined
// CORDIC and product stages.
// A four-entry queue parts the CORDIC from the product pipeline, so each stalls alone.
// Reset clears only valid flags, queue pointers and count; no payload state is kept.
// ----------------------------------------------------------------------------
// euler_xyz_to_rigid_transform
// Converts an x-y-z Euler pose into the nine rotation entries and translation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module euler_xyz_to_rigid_transform import etrt_pkg::*; #(
	parameter int CORDIC_STEPS = 14,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pose_valid,
	output logic   pose_stall,
	input  pose_t  pose,
	output logic   xform_valid,
	input  logic   xform_stall,
	output xform_t xform
);

	// Step and fraction counts beyond the table or the product format are clipped.
	localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
	localparam int FRAC   = (OUT_FRAC_BITS > 30) ? 30 : OUT_FRAC_BITS;

	hs_t   in_hs;
	hs_t   out_hs;
	logic  q_full;
	logic  q_nonempty;
	logic  push;
	logic  pop;
	trig_t trig_w;
	trig_t trig_r;

	// The front pipeline moves as a whole while the queue has room; a beat
	// leaving its last stage always finds a free queue entry.
	assign in_hs.valid = pose_valid;
	assign in_hs.stall = q_full;
	assign pose_stall  = in_hs.stall;

	etrt_front #(
		.NSTEPS(NSTEPS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_hs_i (in_hs),
		.pose_i  (pose),
		.en      (!q_full),
		.push    (push),
		.trig    (trig_w)
	);

	etrt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (trig_w),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.rdata    (trig_r)
	);

	// The back pipeline holds whenever its output register is full and stalled.
	etrt_back #(
		.FRAC(FRAC)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.trig       (trig_r),
		.pop        (pop),
		.out_hs     (out_hs),
		.out_stall  (xform_stall),
		.xform      (xform)
	);

	assign xform_valid = out_hs.valid;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the Euler pose to rigid transform block. Poses are driven
// through a valid/stall channel in random bursts, and every transform beat is
// checked field by field against a bit-exact CORDIC and product model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the transforms still owed by the block and checks each result beat.
class xform_scoreboard;
	etrt_pkg::xform_t owed[$];
	int mismatches;

	function new();
		mismatches = 0;
	endfunction

	// Arithmetic shift with floor rounding on a 64-bit value.
	static function longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	static function longint round_q(longint v, int s);
		if (s == 0)
			return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	static function longint qmul(longint a, longint b);
		return round_q(a * b, 30);
	endfunction

	// Folded rotation-mode CORDIC giving sine and cosine in Q.30.
	static function void sin_cos(logic signed [15:0] ang, output longint s,
			output longint c);
		longint z, x, y, dx, dy;
		bit flip;
		int n;
		z = longint'(ang) * 131072;
		x = 64'(etrt_pkg::Q30_GAIN);
		y = 0;
		flip = 0;
		n = 14;
		if (z > longint'(etrt_pkg::Q30_HALF_PI)) begin
			z -= longint'(etrt_pkg::Q30_PI);
			flip = 1;
		end else if (z < -longint'(etrt_pkg::Q30_HALF_PI)) begin
			z += longint'(etrt_pkg::Q30_PI);
			flip = 1;
		end
		for (int i = 0; i < n; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(etrt_pkg::atan_q30(i));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(etrt_pkg::atan_q30(i));
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	static function logic [15:0] to_q14(longint v);
		longint r;
		r = round_q(v, 16);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return r[15:0];
	endfunction

	// Works out the transform for an accepted pose and queues it.
	function void note_pose(etrt_pkg::pose_t p);
		etrt_pkg::xform_t t;
		longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
		sin_cos(p.angle_x, sx, cx);
		sin_cos(p.angle_y, sy, cy);
		sin_cos(p.angle_z, sz, cz);
		sxsy = qmul(sx, sy);
		cxsy = qmul(cx, sy);
		t.r00 = to_q14(qmul(cy, cz));
		t.r01 = to_q14(-qmul(cy, sz));
		t.r02 = to_q14(sy);
		t.r10 = to_q14(qmul(sxsy, cz) + qmul(cx, sz));
		t.r11 = to_q14(-qmul(sxsy, sz) + qmul(cx, cz));
		t.r12 = to_q14(-qmul(sx, cy));
		t.r20 = to_q14(-qmul(cxsy, cz) + qmul(sx, sz));
		t.r21 = to_q14(qmul(cxsy, sz) + qmul(sx, cz));
		t.r22 = to_q14(qmul(cx, cy));
		t.out_shift_x = p.shift_x;
		t.out_shift_y = p.shift_y;
		t.out_shift_z = p.shift_z;
		owed.insert(owed.size(), t);
	endfunction

	function void report(string what, longint e, longint a);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d, got %0d", what, e, a);
	endfunction

	// Compares one result beat with the oldest owed transform.
	function void check_xform(etrt_pkg::xform_t got);
		etrt_pkg::xform_t e;
		if (owed.size() == 0) begin
			report("unexpected beat", 0, 1);
			return;
		end
		e = owed.pop_front();
		if (got.r00 !== e.r00) report("r00", e.r00, got.r00);
		if (got.r01 !== e.r01) report("r01", e.r01, got.r01);
		if (got.r02 !== e.r02) report("r02", e.r02, got.r02);
		if (got.r10 !== e.r10) report("r10", e.r10, got.r10);
		if (got.r11 !== e.r11) report("r11", e.r11, got.r11);
		if (got.r12 !== e.r12) report("r12", e.r12, got.r12);
		if (got.r20 !== e.r20) report("r20", e.r20, got.r20);
		if (got.r21 !== e.r21) report("r21", e.r21, got.r21);
		if (got.r22 !== e.r22) report("r22", e.r22, got.r22);
		if (got.out_shift_x !== e.out_shift_x)
			report("out_shift_x", e.out_shift_x, got.out_shift_x);
		if (got.out_shift_y !== e.out_shift_y)
			report("out_shift_y", e.out_shift_y, got.out_shift_y);
		if (got.out_shift_z !== e.out_shift_z)
			report("out_shift_z", e.out_shift_z, got.out_shift_z);
	endfunction
endclass

module tb_top;
	import etrt_pkg::*;

	// Rough pose-to-transform delay for the default step count, with margin for the drain wait.
	localparam int LATENCY = 14 + 5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pose_valid = 1'b0;
	logic pose_stall;
	pose_t pose = '0;
	logic xform_valid;
	logic xform_stall = 1'b0;
	xform_t xform;

	xform_scoreboard board = new();
	bit stim_done = 1'b0;
	// Set by the sender to ask the receiver for a long hold-off.
	bit hold_req = 1'b0;

	euler_xyz_to_rigid_transform dut (
		.clk(clk),
		.arst_n(arst_n),
		.pose_valid(pose_valid),
		.pose_stall(pose_stall),
		.pose(pose),
		.xform_valid(xform_valid),
		.xform_stall(xform_stall),
		.xform(xform)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Angle picker: mostly anywhere in range, sometimes on the fold
	// boundaries at plus and minus pi/2, the range ends, or near pi.
	function automatic logic [15:0] pick_angle();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 16'(12868 + $urandom_range(0, 4) - 2);
			1: return 16'(-12868 + $urandom_range(0, 4) - 2);
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			3: return 16'(25736 + $urandom_range(0, 4) - 2);
			default: return 16'($urandom);
		endcase
	endfunction

	// Offers one pose beat at the falling edge and holds it until the block
	// takes it; the scoreboard notes the pose at the accepting rising edge.
	task automatic send_pose(pose_t p);
		pose_valid <= 1'b1;
		pose <= p;
		do
			@(posedge clk);
		while (pose_stall);
		board.note_pose(p);
		@(negedge clk);
	endtask

	task automatic idle_sender(int n);
		pose_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic make_pose(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
			logic [31:0] tx, logic [31:0] ty, logic [31:0] tz, output pose_t p);
		p.angle_x = ax;
		p.angle_y = ay;
		p.angle_z = az;
		p.shift_x = tx;
		p.shift_y = ty;
		p.shift_z = tz;
	endtask

	task automatic wait_drained();
		pose_valid <= 1'b0;
		while (board.owed.size() != 0)
			@(negedge clk);
	endtask

	// Sender: a directed set first, then random bursts with random gaps.
	initial begin
		pose_t p;
		int burst;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero pose, range ends, fold boundaries and quarter turns.
		make_pose(16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, p);
		send_pose(p);
		make_pose(16'h7fff, 16'h8000, 16'h7fff, 32'h7fffffff, 32'h80000000,
			32'hffffffff, p);
		send_pose(p);
		make_pose(16'h8000, 16'h7fff, 16'h8000, 32'h80000000, 32'h7fffffff,
			32'h00000001, p);
		send_pose(p);
		make_pose(16'd12868, 16'd12867, 16'd12869, 32'h55555555, 32'haaaaaaaa,
			32'h12345678, p);
		send_pose(p);
		make_pose(-16'sd12868, -16'sd12867, -16'sd12869, 32'haaaaaaaa,
			32'h55555555, 32'hedcba987, p);
		send_pose(p);
		// Half turns, where saturation near one is likely.
		make_pose(16'd25736, -16'sd25736, 16'd0, 32'hffffffff, 32'h0, 32'h1, p);
		send_pose(p);
		make_pose(16'd0, 16'd12868, 16'd25736, 32'h0, 32'hffffffff, 32'h0, p);
		send_pose(p);
		make_pose(16'hffff, 16'h0001, 16'hffff, 32'h1, 32'h1, 32'h1, p);
		send_pose(p);
		for (int i = 0; i < 8; i++) begin
			make_pose(16'(i * 4096), 16'(-i * 4096), 16'(i * 8191), 32'($urandom),
				32'($urandom), 32'($urandom), p);
			send_pose(p);
		end

		// Pause with nothing in flight before the random part.
		wait_drained();

		for (int n = 0; n < 1750; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++) begin
				make_pose(pick_angle(), pick_angle(), pick_angle(), $urandom,
					$urandom, $urandom, p);
				send_pose(p);
				n++;
			end
			// Ask for a long hold-off once, well into the run, and keep sending.
			if (n > 600 && n < 650)
				hold_req = 1'b1;
			if ($urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 12));
			else if ($urandom_range(0, 60) == 0)
				wait_drained();
		end
		pose_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: stalls on its own random pattern, with quiet stretches that
	// never stall and one long hold-off that backs the block up to its input.
	initial begin
		int mode;
		int left;
		bit held;
		mode = 0;
		left = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				xform_stall <= 1'b1;
				repeat (200) @(negedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(10, 80);
			end
			left--;
			case (mode)
				0: xform_stall <= 1'b0;
				1: xform_stall <= ($urandom_range(0, 3) == 0);
				default: xform_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// Result beats are checked at the rising edge that accepts them.
	always @(posedge clk) begin
		if (arst_n && xform_valid && !xform_stall)
			board.check_xform(xform);
	end

	// End of run: all poses sent, nothing owed, then a short quiet wait so a
	// stray extra beat would still be caught.
	initial begin
		wait (stim_done);
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);
		if (board.mismatches == 0 && board.owed.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
